// ===== hdl/ttx_pkg.sv =====
// ----------------------------------------------------------------------------
// ttx_pkg: shared types and constants of the temperature table
// Operation codes, widths, reset values of the statistics, the controller
// state type and the command and status bundles between the two halves.
// ----------------------------------------------------------------------------
package ttx_pkg;

	localparam int OP_W       = 2;
	localparam int INDEX_W    = 8;
	localparam int SAMPLE_W   = 8;
	localparam int FIELD_W    = 6;
	localparam int RDATA_W    = 24;
	localparam int GROUP_SIZE = 4;

	localparam logic [INDEX_W-1:0]  STATS_INDEX = 8'hFF;
	localparam logic [SAMPLE_W-1:0] MAX_INIT    = 8'h00;
	localparam logic [SAMPLE_W-1:0] MIN_INIT    = 8'hFF;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_COMMIT = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SCAN,
		S_READ,
		S_GROUP,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_stats;
		logic write;
		logic scan;
		logic issue;
		logic pack_fixed;
		logic reply;
	} ttx_cmd_t;

	typedef struct packed {
		logic cnt_at_end;
		logic cnt_at_grp;
		logic pend;
		logic grp_ok;
	} ttx_status_t;

endpackage

// ===== hdl/ttx_ram.sv =====
// ----------------------------------------------------------------------------
// ttx_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ttx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/ttx_dp.sv =====
// ----------------------------------------------------------------------------
// ttx_dp: datapath of the temperature table
// Sample memory with per-slot valid bits, walk counter, top-two extremes,
// packing register (which is also the result register) and the result strobe.
// ----------------------------------------------------------------------------
module ttx_dp import ttx_pkg::*; #(
	parameter int SLOTS = 36
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [INDEX_W-1:0]  index,
	input  logic [SAMPLE_W-1:0] value,
	input  ttx_cmd_t            cmd,
	output ttx_status_t         status,
	output logic [RDATA_W-1:0]  read_data,
	output logic                done
);

	localparam int AW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int IXW = INDEX_W + 1;
	localparam logic [CW-1:0]  CNT_END  = CW'(SLOTS);
	localparam logic [CW-1:0]  CNT_GRP  = CW'(GROUP_SIZE);
	localparam logic [IXW-1:0] SLOTS_X  = IXW'(SLOTS);
	localparam logic [IXW-1:0] GROUPS_X = IXW'(SLOTS / GROUP_SIZE);

	logic [INDEX_W-1:0]   index_q;
	logic [SAMPLE_W-1:0]  value_q;
	logic [CW-1:0]        cnt_q;
	logic                 scan_s1;
	logic                 grp_s1;
	logic                 vld_s1;
	logic [SLOTS-1:0]     valid_q;
	logic [SAMPLE_W-1:0]  max0_q, max1_q, min0_q, min1_q;
	logic [RDATA_W-1:0]   pack_q;
	logic                 done_q;

	logic [INDEX_W+1:0]   grp_addr;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic                 wr_ok;
	logic                 we;
	logic [SAMPLE_W-1:0]  ram_rdata;
	logic [SAMPLE_W-1:0]  sample;

	assign grp_addr = {index_q, cnt_q[1:0]};
	assign raddr    = cmd.scan ? cnt_q[AW-1:0] : grp_addr[AW-1:0];
	assign waddr    = index_q[AW-1:0];
	assign wr_ok    = {1'b0, index_q} < SLOTS_X;
	assign we       = cmd.write & wr_ok;
	// A slot never written since reset reads as zero.
	assign sample   = vld_s1 ? ram_rdata : '0;

	ttx_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value_q),
		.re    (cmd.issue),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			index_q <= index;
			value_q <= value;
		end
		if (cmd.issue) begin
			vld_s1 <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
			scan_s1 <= 1'b0;
			grp_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			scan_s1 <= cmd.issue & cmd.scan;
			grp_s1  <= cmd.issue & ~cmd.scan;
			done_q  <= cmd.reply;
		end
	end

	// Top-two walk: ties take the lead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max0_q <= MAX_INIT;
			max1_q <= MAX_INIT;
			min0_q <= MIN_INIT;
			min1_q <= MIN_INIT;
		end else if (cmd.clr_stats) begin
			max0_q <= MAX_INIT;
			max1_q <= MAX_INIT;
			min0_q <= MIN_INIT;
			min1_q <= MIN_INIT;
		end else if (scan_s1) begin
			if (sample >= max0_q) begin
				max1_q <= max0_q;
				max0_q <= sample;
			end else if (sample > max1_q) begin
				max1_q <= sample;
			end
			if (sample <= min0_q) begin
				min1_q <= min0_q;
				min0_q <= sample;
			end else if (sample < min1_q) begin
				min1_q <= sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack_fixed) begin
			if (index_q == STATS_INDEX) begin
				pack_q <= {max0_q[FIELD_W-1:0], max1_q[FIELD_W-1:0],
				           min0_q[FIELD_W-1:0], min1_q[FIELD_W-1:0]};
			end else begin
				pack_q <= '0;
			end
		end else if (grp_s1) begin
			pack_q <= {pack_q[RDATA_W-FIELD_W-1:0], sample[FIELD_W-1:0]};
		end
	end

	assign status.cnt_at_end = (cnt_q == CNT_END);
	assign status.cnt_at_grp = (cnt_q == CNT_GRP);
	assign status.pend       = scan_s1 | grp_s1;
	assign status.grp_ok     = {1'b0, index_q} < GROUPS_X;

	assign read_data = pack_q;
	assign done      = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_END)
		else $error("walk counter ran past the table");

	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		scan_s1 |-> !grp_s1)
		else $error("scan and group read data in flight together");

endmodule

// ===== hdl/ttx_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttx_ctrl: controller of the temperature table
// Decodes the command at acceptance and sequences writes, the commit walk
// and packed reads through the datapath.
// ----------------------------------------------------------------------------
module ttx_ctrl import ttx_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] operation,
	input  ttx_status_t     status,
	output ttx_cmd_t        cmd,
	output logic            busy
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start & (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (op_t'(operation))
						OP_WRITE: begin
							state_d = S_WRITE;
						end
						OP_COMMIT: begin
							cmd.clr_stats = 1'b1;
							state_d       = S_SCAN;
						end
						OP_READ: begin
							state_d = S_READ;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan  = 1'b1;
				cmd.issue = ~status.cnt_at_end;
				if (status.cnt_at_end && !status.pend) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				if (status.grp_ok) begin
					state_d = S_GROUP;
				end else begin
					cmd.pack_fixed = 1'b1;
					state_d        = S_REPLY;
				end
			end
			S_GROUP: begin
				cmd.issue = ~status.cnt_at_grp;
				if (status.cnt_at_grp && !status.pend) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				cmd.reply = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_commit_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_COMMIT) |=> (state_q == S_SCAN))
		else $error("accepted commit did not start the walk");

	a_reply_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reply |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after a result");

endmodule

// ===== hdl/temperature_table_top_two_extremes_top.sv =====
// ----------------------------------------------------------------------------
// temperature_table_top_two_extremes_top: temperature table with extremes
// Stores SLOTS temperature bytes, recomputes the two largest and two smallest
// on a commit, and returns packed groups of 6-bit values on a read.
// ----------------------------------------------------------------------------
// A write keeps busy high through the S_WRITE state; a commit keeps it high
// through the walk, one sample memory read per cycle, then while the last
// sample lands and the walk is seen drained.
// A group read strobes done after S_READ, S_GROUP and S_REPLY (four reads on
// the single memory port); a statistics or bad-index read skips S_GROUP.
// Throughput: one transaction at a time; the next may start once busy falls.
// Reset (arst_n low) clears the table to zero through valid bits at once,
// and sets max to 0 and min to 255; the result strobe has no stall input.
module temperature_table_top_two_extremes_top import ttx_pkg::*; #(
	parameter int SLOTS = 36
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     operation,
	input  logic [INDEX_W-1:0]  index,
	input  logic [SAMPLE_W-1:0] value,
	output logic [RDATA_W-1:0]  read_data,
	output logic                done
);

	// Command and status bundles between the controller and the datapath.
	ttx_cmd_t    cmd;
	ttx_status_t status;

	// The controller decodes the operation when a transaction is accepted and
	// then steps the datapath: a write is done in the S_WRITE state, a commit walks
	// the table from slot 0 upward, and a read either collects four slots or
	// packs the statistics (or zero for an index that names nothing).
	ttx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// The datapath holds the sample memory, the walk counter, the running
	// top-two maximum and minimum, and the register that drives read_data.
	// The read_data value stays put until the next read is packed, and done
	// marks the one cycle in which the result is taken.
	ttx_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.index     (index),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.read_data (read_data),
		.done      (done)
	);

endmodule
